// ===== rtl/bezier_point_evaluator_assert.svh =====
// Assertion macros used by the bezier point evaluator checker.
// No dependencies; included by bpe_checker.sv.
`ifndef BEZIER_POINT_EVALUATOR_ASSERT_SVH
`define BEZIER_POINT_EVALUATOR_ASSERT_SVH

// clocked assertion, masked while reset is active
`define BPE_ASSERT_RST(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("%m: label failed");

// clocked assertion, also checked through reset
`define BPE_ASSERT_CLK(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("%m: label failed");

`endif

// ===== rtl/bpe_pkg.sv =====
// Shared constants for the bezier point evaluator.
// Used by bpe_cell, bezier_point_evaluator and bpe_checker.
package bpe_pkg;

	localparam int MAX_POINTS_DEF = 4;
	localparam int COORD_BITS_DEF = 16;
	localparam int NUM_POINT_REGS = 4;

	localparam int CNT_W = 3;
	localparam int T_W = 17;
	localparam int T_FRAC = 16;
	localparam logic [T_W-1:0] T_ONE = 17'h10000;

	localparam int HALF_W = 16;
	localparam int OUT_W = 16;
	localparam int CFG_W = 32;
	localparam int REG_IDX_W = 3;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_POINT_A = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_POINT_B = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_POINT_C = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_POINT_D = 3'd4;

endpackage

// ===== rtl/bpe_cell.sv =====
// One interpolation cell: registered a + floor((b - a) * t / 2^16) on x and y, or a when en is low.
// Depends on bpe_pkg.
module bpe_cell #(
	parameter int CW = bpe_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        ce,
	input  logic                        en,
	input  logic [bpe_pkg::T_W-1:0]     t,
	input  logic signed [CW-1:0]        ax,
	input  logic signed [CW-1:0]        ay,
	input  logic signed [CW-1:0]        bx,
	input  logic signed [CW-1:0]        by,
	output logic signed [CW-1:0]        px_q,
	output logic signed [CW-1:0]        py_q
);
	import bpe_pkg::*;

	localparam int PW = CW + T_W + 2;

	logic signed [CW:0]   dx, dy;
	logic signed [T_W:0]  ts;
	logic signed [PW-1:0] mx, my;
	logic [CW-1:0]        nx, ny;

	assign ts = $signed({1'b0, t});
	assign dx = $signed({bx[CW-1], bx}) - $signed({ax[CW-1], ax});
	assign dy = $signed({by[CW-1], by}) - $signed({ay[CW-1], ay});
	assign mx = dx * ts;
	assign my = dy * ts;
	// arithmetic shift of the product is the floor; result stays between a and b
	assign nx = ax + mx[T_FRAC +: CW];
	assign ny = ay + my[T_FRAC +: CW];

	always_ff @(posedge clk) begin
		if (ce) begin
			px_q <= en ? $signed(nx) : ax;
			py_q <= en ? $signed(ny) : ay;
		end
	end

endmodule

// ===== rtl/bezier_point_evaluator.sv =====
// Bezier point evaluator top level: config registers and the chain of lerp cells.
// Depends on bpe_pkg and bpe_cell.
//
// Usage:
//   cfg_we/cfg_index/cfg_data write point_count (index 0) and control points
//   a..d (index 1..4, x in bits 15:0, y in bits 31:16). Write only while idle.
//   Input words on s_t* carry t_param (16 fraction bits, above 1.0 saturates).
//   Output words on m_t* carry the curve point (x low half, y high half).
// Timing:
//   One word per cycle sustained while m_tready stays high. A capture stage,
//   then one row of cells per de Casteljau level.
//   Point counts below the maximum pass through the leading levels unchanged.
// Stall:
//   Each stage has its own valid bit and advances when the next one is empty
//   or moving, so empty stages keep filling while m_tready is low; s_tready
//   drops only when every stage holds a word.
// Reset:
//   arst_n clears all valid bits, point_count and the control points.
module bezier_point_evaluator #(
	parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = bpe_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bpe_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [bpe_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bpe_pkg::S_TDATA_W-1:0]     s_tdata,   // [16:0] t_param
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bpe_pkg::M_TDATA_W-1:0]     m_tdata    // [15:0] x_coord, [31:16] y_coord
);
	import bpe_pkg::*;

	localparam int NP = (MAX_POINTS < NUM_POINT_REGS) ? MAX_POINTS : NUM_POINT_REGS;
	localparam int CW = (COORD_BITS < HALF_W) ? COORD_BITS : HALF_W;
	localparam logic [CNT_W:0] NP_C = (CNT_W + 1)'(NP);

	logic [CNT_W-1:0] point_count_q;
	logic [CFG_W-1:0] cp_q [NUM_POINT_REGS];

	logic [CNT_W-1:0] cnt_in;
	logic [T_W-1:0]   t_in;

	logic                vld_s [NP];
	logic [T_W-1:0]      t_s   [NP];
	logic [CNT_W-1:0]    cnt_s [NP];
	logic signed [CW-1:0] x0_s [NP];
	logic signed [CW-1:0] y0_s [NP];
	logic signed [CW-1:0] x_s  [NP][NP];
	logic signed [CW-1:0] y_s  [NP][NP];
	logic                rdy   [NP+1];
	logic signed [OUT_W-1:0] x_out, y_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			for (int i = 0; i < NUM_POINT_REGS; i++) begin
				cp_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POINT_COUNT: point_count_q <= cfg_data[CNT_W-1:0];
				REG_POINT_A:     cp_q[0] <= cfg_data;
				REG_POINT_B:     cp_q[1] <= cfg_data;
				REG_POINT_C:     cp_q[2] <= cfg_data;
				REG_POINT_D:     cp_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cnt_in = ({1'b0, point_count_q} > NP_C) ? NP_C[CNT_W-1:0] : point_count_q;
	assign t_in = (s_tdata[T_W-1:0] > T_ONE) ? T_ONE : s_tdata[T_W-1:0];

	assign rdy[NP] = m_tready;

	// capture stage: unused points read as zero, so a count of zero gives the origin
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			t_s[0]   <= t_in;
			cnt_s[0] <= cnt_in;
			for (int i = 0; i < NP; i++) begin
				x0_s[i] <= (CNT_W'(i) < cnt_in) ? $signed(cp_q[i][CW-1:0]) : '0;
				y0_s[i] <= (CNT_W'(i) < cnt_in) ? $signed(cp_q[i][HALF_W +: CW]) : '0;
			end
		end
	end

	genvar k, i;
	generate
		for (i = 0; i < NP; i++) begin : g_s0
			assign x_s[0][i] = x0_s[i];
			assign y_s[0][i] = y0_s[i];
		end

		for (k = 0; k < NP; k++) begin : g_stage
			assign rdy[k] = !vld_s[k] || rdy[k+1];

			if (k == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_s[k] <= 1'b0;
					end else if (rdy[k]) begin
						vld_s[k] <= s_tvalid;
					end
				end
			end else begin : g_level
				logic en;

				// leading levels idle so a short curve lands on cell 0 of the last row
				assign en = ((CNT_W + 1)'(k - 1) + {1'b0, cnt_s[k-1]}) >= NP_C;

				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_s[k] <= 1'b0;
					end else if (rdy[k]) begin
						vld_s[k] <= vld_s[k-1];
					end
				end

				always_ff @(posedge clk) begin
					if (rdy[k]) begin
						t_s[k]   <= t_s[k-1];
						cnt_s[k] <= cnt_s[k-1];
					end
				end

				for (i = 0; i < NP - k; i++) begin : g_cell
					bpe_cell #(
						.CW(CW)
					) u_cell (
						.clk  (clk),
						.ce   (rdy[k]),
						.en   (en),
						.t    (t_s[k-1]),
						.ax   (x_s[k-1][i]),
						.ay   (y_s[k-1][i]),
						.bx   (x_s[k-1][i+1]),
						.by   (y_s[k-1][i+1]),
						.px_q (x_s[k][i]),
						.py_q (y_s[k][i])
					);
				end
			end
		end
	endgenerate

	assign x_out = OUT_W'(x_s[NP-1][0]);
	assign y_out = OUT_W'(y_s[NP-1][0]);

	assign s_tready = rdy[0];
	assign m_tvalid = vld_s[NP-1];
	assign m_tdata  = {y_out, x_out};

endmodule

// ===== rtl/bpe_checker.sv =====
// Port-level checker for bezier_point_evaluator, attached by bind.
// Depends on bpe_pkg and bezier_point_evaluator_assert.svh.
`include "bezier_point_evaluator_assert.svh"

module bpe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bpe_pkg::M_TDATA_W-1:0] m_tdata
);
	import bpe_pkg::*;

	// stalled word holds
	`BPE_ASSERT_RST(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	// an empty output stage means the whole chain can take a word
	`BPE_ASSERT_RST(a_ready_when_drained, clk, arst_n, !m_tvalid |-> s_tready)
	// input backpressure only happens with a word waiting at the output
	`BPE_ASSERT_RST(a_stall_cause, clk, arst_n, s_tvalid && !s_tready |-> m_tvalid && !m_tready)
	// nothing comes out of reset
	`BPE_ASSERT_CLK(a_reset_empty, clk, $rose(arst_n) |-> !m_tvalid)

endmodule

bind bezier_point_evaluator bpe_checker u_bpe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
